@@ hw/rtl/arm64_page_table_walker_assert.svh @@
// assertion macros used by the page table walker rtl
`ifndef ARM64_PAGE_TABLE_WALKER_ASSERT_SVH
`define ARM64_PAGE_TABLE_WALKER_ASSERT_SVH

// implication checked on every rising edge outside reset
`define APTW_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check, but also active while reset is asserted
`define APTW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/aptw_pkg.sv @@
// types, codes and table helpers for the page table walker
package aptw_pkg;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DESC  = 1'b1
  } aptw_cmd_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2,
    KIND_UNEXP = 2'd3
  } aptw_kind_t;

  localparam logic [1:0] REG_GRANULE    = 2'd0;
  localparam logic [1:0] REG_LEVEL_CNT  = 2'd1;
  localparam logic [1:0] REG_TABLE_BASE = 2'd2;

  localparam logic [1:0] GRAN_16K = 2'd1;
  localparam logic [1:0] GRAN_64K = 2'd2;

  localparam logic [1:0] DESC_TABLE_PAGE = 2'b11;
  localparam logic [1:0] DESC_BLOCK      = 2'b01;
  localparam logic [1:0] LAST_LEVEL      = 2'd3;

  localparam int unsigned VA_W   = 48;
  localparam int unsigned DESC_W = 64;
  localparam int unsigned IDX_W  = 13;

  typedef struct packed {
    aptw_cmd_t           cmd;
    logic [VA_W-1:0]     virt_addr;
    logic [DESC_W-1:0]   descriptor;
  } aptw_in_t;

  typedef struct packed {
    aptw_kind_t          kind;
    logic [VA_W-1:0]     address;
    logic [1:0]          walk_level;
  } aptw_out_t;

  typedef struct packed {
    logic [1:0]          granule_code;
    logic [2:0]          level_count;
    logic [VA_W-1:0]     table_base;
  } aptw_cfg_t;

  // log2 of the granule size
  function automatic logic [5:0] gran_shift(input logic [1:0] gran);
    logic [5:0] s;
    case (gran)
      GRAN_16K: s = 6'd14;
      GRAN_64K: s = 6'd16;
      default:  s = 6'd12;
    endcase
    return s;
  endfunction

  // lowest va bit translated at a level; at the last level this is the page size
  function automatic logic [5:0] lvl_shift(input logic [1:0] gran, input logic [1:0] lv);
    logic [5:0] s;
    logic [5:0] b;
    logic [1:0] up;
    s  = gran_shift(gran);
    b  = s - 6'd3;
    up = LAST_LEVEL - lv;
    return 6'(s + 6'(b * {4'd0, up}));
  endfunction

  // table index width mask per granule
  function automatic logic [IDX_W-1:0] idx_mask(input logic [1:0] gran);
    logic [IDX_W-1:0] m;
    case (gran)
      GRAN_16K: m = 13'h07FF;
      GRAN_64K: m = 13'h1FFF;
      default:  m = 13'h01FF;
    endcase
    return m;
  endfunction

  // ones in the bits below n
  function automatic logic [DESC_W-1:0] low_mask(input logic [5:0] n);
    return ~({DESC_W{1'b1}} << n);
  endfunction

endpackage

@@ hw/rtl/aptw_cfg.sv @@
// configuration registers of the page table walker
module aptw_cfg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [1:0]            wr_index,
  input  logic [47:0]           wr_data,
  output aptw_pkg::aptw_cfg_t   cfg
);

  logic [1:0]  granule_r;
  logic [2:0]  level_cnt_r;
  logic [47:0] table_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      granule_r    <= 2'd0;
      level_cnt_r  <= 3'd4;
      table_base_r <= 48'd0;
    end else if (wr_en) begin
      case (wr_index)
        aptw_pkg::REG_GRANULE:    granule_r    <= wr_data[1:0];
        aptw_pkg::REG_LEVEL_CNT:  level_cnt_r  <= wr_data[2:0];
        aptw_pkg::REG_TABLE_BASE: table_base_r <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg.granule_code = granule_r;
  assign cfg.level_count  = level_cnt_r;
  assign cfg.table_base   = table_base_r;

endmodule

@@ hw/rtl/aptw_walk.sv @@
// walk state and the per-request descriptor step
`include "arm64_page_table_walker_assert.svh"

module aptw_walk #(
  parameter int unsigned PA_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  aptw_pkg::aptw_in_t    req,
  input  aptw_pkg::aptw_cfg_t   cfg,
  output aptw_pkg::aptw_out_t   res
);

  localparam logic [63:0] PA_MASK = (PA_BITS >= 64) ? {64{1'b1}} :
                                    ((64'd1 << PA_BITS) - 64'd1);

  logic        walking_r, walking_nxt;
  logic [1:0]  level_r, level_nxt;
  logic [47:0] saved_r, saved_nxt;

  logic [1:0]  start_lv;
  logic [1:0]  req_lv;
  logic [47:0] vaddr_use;
  logic [5:0]  g_shift;
  logic [63:0] g_mask;
  logic [47:0] req_base;
  logic [12:0] idx;
  logic [47:0] req_addr;
  logic [5:0]  term_bits;
  logic [63:0] term_mask;
  logic [63:0] done_wide;
  logic [1:0]  d_type;
  logic        is_start;

  assign is_start  = (req.cmd == aptw_pkg::CMD_START);
  assign d_type    = req.descriptor[1:0];
  assign g_shift   = aptw_pkg::gran_shift(cfg.granule_code);
  assign g_mask    = aptw_pkg::low_mask(g_shift);

  // level count clamps to 1..4, start level is 4 minus the count
  always_comb begin
    case (cfg.level_count)
      3'd2:    start_lv = 2'd2;
      3'd3:    start_lv = 2'd1;
      3'd0,
      3'd1:    start_lv = 2'd3;
      default: start_lv = 2'd0;
    endcase
  end

  assign vaddr_use = is_start ? req.virt_addr : saved_r;
  assign req_lv    = is_start ? start_lv : 2'(level_r + 2'd1);
  assign req_base  = is_start ? (cfg.table_base & PA_MASK[47:0] & ~g_mask[47:0])
                              : 48'(req.descriptor & PA_MASK & ~g_mask);
  assign idx       = 13'(vaddr_use >> aptw_pkg::lvl_shift(cfg.granule_code, req_lv))
                     & aptw_pkg::idx_mask(cfg.granule_code);
  assign req_addr  = req_base + {32'd0, idx, 3'b000};

  // page or block: output address bits above the block size, va bits below
  assign term_bits = aptw_pkg::lvl_shift(cfg.granule_code, level_r);
  assign term_mask = aptw_pkg::low_mask(term_bits);
  assign done_wide = (req.descriptor & PA_MASK & ~term_mask) | ({16'd0, saved_r} & term_mask);

  always_comb begin
    walking_nxt    = walking_r;
    level_nxt      = level_r;
    saved_nxt      = saved_r;
    res.kind       = aptw_pkg::KIND_FAULT;
    res.address    = 48'd0;
    res.walk_level = level_r;
    if (is_start) begin
      res.kind       = aptw_pkg::KIND_READ;
      res.address    = req_addr;
      res.walk_level = start_lv;
      walking_nxt    = 1'b1;
      level_nxt      = start_lv;
      saved_nxt      = req.virt_addr;
    end else if (!walking_r) begin
      res.kind = aptw_pkg::KIND_UNEXP;
    end else if (d_type == aptw_pkg::DESC_TABLE_PAGE && level_r != aptw_pkg::LAST_LEVEL) begin
      res.kind       = aptw_pkg::KIND_READ;
      res.address    = req_addr;
      res.walk_level = req_lv;
      level_nxt      = req_lv;
    end else if ((d_type == aptw_pkg::DESC_TABLE_PAGE) ||
                 (d_type == aptw_pkg::DESC_BLOCK && level_r != aptw_pkg::LAST_LEVEL)) begin
      res.kind    = aptw_pkg::KIND_DONE;
      res.address = done_wide[47:0];
      walking_nxt = 1'b0;
    end else begin
      walking_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walking_r <= 1'b0;
      level_r   <= 2'd0;
      saved_r   <= 48'd0;
    end else if (fire) begin
      walking_r <= walking_nxt;
      level_r   <= level_nxt;
      saved_r   <= saved_nxt;
    end
  end

  `APTW_ASSERT_CLK(a_start_walks, fire && is_start |=> walking_r, "start did not begin a walk")
  `APTW_ASSERT_CLK(a_idle_desc_keeps, fire && !is_start && !walking_r |=> !walking_r && $stable(level_r), "stray descriptor changed walk state")
  `APTW_ASSERT_CLK(a_done_ends, fire && (res.kind == aptw_pkg::KIND_DONE || res.kind == aptw_pkg::KIND_FAULT) |=> !walking_r, "walk still active after it ended")
  `APTW_ASSERT_ALWAYS(a_fault_no_addr, (res.kind == aptw_pkg::KIND_FAULT || res.kind == aptw_pkg::KIND_UNEXP) |-> res.address == 48'd0, "fault carries an address")

endmodule

@@ hw/rtl/arm64_page_table_walker.sv @@
// page table walker top: input register, walk step, result register
// path: a request is held in the input register, then its step result in the result register
// throughput: one request per cycle while the result is not stalled, each request is one walk step of the step logic
// the input stalls only while both registers are full and the result is stalled
// reset (rst_n low, synchronous): idle, level 0, 4 KiB granule, four levels, base 0
module arm64_page_table_walker #(
  parameter int unsigned PA_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  aptw_pkg::aptw_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output aptw_pkg::aptw_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [47:0]          cfg_data
);

  logic                s1_valid_r, s1_valid_nxt;
  aptw_pkg::aptw_in_t  s1_data_r;
  logic                out_valid_r, out_valid_nxt;
  aptw_pkg::aptw_out_t out_data_r;
  logic                advance;
  logic                in_take;
  aptw_pkg::aptw_cfg_t cfg;
  aptw_pkg::aptw_out_t step_res;

  assign cfg_ready = 1'b1;

  aptw_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  aptw_walk #(.PA_BITS(PA_BITS)) u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .req   (s1_data_r),
    .cfg   (cfg),
    .res   (step_res)
  );

  // request moves on when the result register is empty or being drained
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the arm64 page table walker: directed and random walks against a scoreboard
module testbench;

  localparam int PA_W        = 48;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE      = 8;
  localparam int CHUNK       = 84;
  localparam logic [63:0] PA_MASK = (64'd1 << PA_W) - 64'd1;

  // predicts walker results from the accepted requests and checks them in order
  class walk_scoreboard;
    logic [1:0]  granule;
    logic [2:0]  levels;
    logic [47:0] base;
    bit          walking;
    logic [1:0]  level;
    logic [47:0] vaddr;
    aptw_pkg::aptw_out_t expected_q[$];
    int          mismatches;

    function new();
      granule    = 2'd0;
      levels     = 3'd4;
      base       = '0;
      walking    = 1'b0;
      level      = 2'd0;
      vaddr      = '0;
      mismatches = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [47:0] val);
      if (idx == aptw_pkg::REG_GRANULE) granule = val[1:0];
      else if (idx == aptw_pkg::REG_LEVEL_CNT) levels = val[2:0];
      else if (idx == aptw_pkg::REG_TABLE_BASE) base = val;
    endfunction

    function int unsigned page_shift();
      if (granule == aptw_pkg::GRAN_16K) return 14;
      if (granule == aptw_pkg::GRAN_64K) return 16;
      return 12;
    endfunction

    function logic [63:0] ones_below(input int unsigned n);
      if (n >= 64) return '1;
      return (64'd1 << n) - 64'd1;
    endfunction

    // descriptor address for the latched va in the table at tbl
    function logic [47:0] entry_addr(input logic [63:0] tbl, input int unsigned lv);
      int unsigned s, b, sh;
      logic [63:0] idx;
      s   = page_shift();
      b   = s - 3;
      sh  = b * (3 - lv) + s;
      idx = ({16'd0, vaddr} >> sh) & ones_below(b);
      return 48'(tbl + idx * 64'd8);
    endfunction

    function void note_request(input aptw_pkg::aptw_in_t req);
      aptw_pkg::aptw_out_t e;
      int unsigned s, b, n, lv, bits;
      logic [63:0] d, pa;
      s = page_shift();
      b = s - 3;
      if (req.cmd == aptw_pkg::CMD_START) begin
        n = levels;
        if (n < 1) n = 1;
        if (n > 4) n = 4;
        vaddr        = req.virt_addr;
        level        = 2'(4 - n);
        walking      = 1'b1;
        e.kind       = aptw_pkg::KIND_READ;
        e.address    = entry_addr({16'd0, base} & PA_MASK & ~ones_below(s), level);
        e.walk_level = level;
      end else if (!walking) begin
        e.kind       = aptw_pkg::KIND_UNEXP;
        e.address    = '0;
        e.walk_level = level;
      end else begin
        d  = req.descriptor;
        lv = level;
        if (d[1:0] == aptw_pkg::DESC_TABLE_PAGE && lv != aptw_pkg::LAST_LEVEL) begin
          level        = 2'(lv + 1);
          e.kind       = aptw_pkg::KIND_READ;
          e.address    = entry_addr(d & PA_MASK & ~ones_below(s), level);
          e.walk_level = level;
        end else if (d[1:0] == aptw_pkg::DESC_TABLE_PAGE ||
                     (d[1:0] == aptw_pkg::DESC_BLOCK && lv != aptw_pkg::LAST_LEVEL)) begin
          // page at the last level, block above it
          bits         = (d[1:0] == aptw_pkg::DESC_TABLE_PAGE) ? s : b * (3 - lv) + s;
          pa           = d & PA_MASK & ~ones_below(bits);
          walking      = 1'b0;
          e.kind       = aptw_pkg::KIND_DONE;
          e.address    = 48'(pa + ({16'd0, vaddr} & ones_below(bits)));
          e.walk_level = 2'(lv);
        end else begin
          walking      = 1'b0;
          e.kind       = aptw_pkg::KIND_FAULT;
          e.address    = '0;
          e.walk_level = 2'(lv);
        end
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(input aptw_pkg::aptw_out_t got);
      aptw_pkg::aptw_out_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no request pending: kind %0d addr %h level %0d",
                   got.kind, got.address, got.walk_level);
        return;
      end
      e = expected_q.pop_front();
      if (got.kind !== e.kind || got.address !== e.address ||
          got.walk_level !== e.walk_level) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected kind %0d addr %h level %0d, got kind %0d addr %h level %0d",
                   e.kind, e.address, e.walk_level, got.kind, got.address, got.walk_level);
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  aptw_pkg::aptw_in_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  aptw_pkg::aptw_out_t out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data  = '0;

  walk_scoreboard sb = new();
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_seq     = 0;
  int          sent         = 0;
  logic [2:0]  levels_now   = 3'd4;

  arm64_page_table_walker #(.PA_BITS(PA_W)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // receiver: random stall, plus a long hold-off when asked
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [63:0] rand64();
    return {32'($urandom), 32'($urandom)};
  endfunction

  function automatic aptw_pkg::aptw_in_t start_req(input logic [47:0] va);
    aptw_pkg::aptw_in_t r;
    r.cmd        = aptw_pkg::CMD_START;
    r.virt_addr  = va;
    r.descriptor = rand64();
    return r;
  endfunction

  function automatic aptw_pkg::aptw_in_t desc_req(input logic [63:0] d);
    aptw_pkg::aptw_in_t r;
    r.cmd        = aptw_pkg::CMD_DESC;
    r.virt_addr  = rand48();
    r.descriptor = d;
    return r;
  endfunction

  // each cycle before the request goes out is idle with the sender's idle odds
  task automatic send_request(input aptw_pkg::aptw_in_t req);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // stop offering requests until every result is back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] gran, input logic [2:0] lvls,
                           input logic [47:0] tbase);
    logic [1:0]  idx [3];
    logic [47:0] val [3];
    idx = '{aptw_pkg::REG_GRANULE, aptw_pkg::REG_LEVEL_CNT, aptw_pkg::REG_TABLE_BASE};
    val = '{{46'd0, gran}, {45'd0, lvls}, tbase};
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid  <= 1'b0;
    levels_now = lvls;
  endtask

  // one walk from the top level, sometimes restarted midway: tables down, ending in a block, page or fault
  task automatic run_walk();
    aptw_pkg::aptw_in_t req;
    int unsigned top, lv, pick;
    bit          done;
    top = (levels_now == 0) ? 3 : (levels_now >= 4) ? 0 : 4 - levels_now;
    lv  = top;
    send_request(start_req(rand48()));
    done = 1'b0;
    while (!done) begin
      req  = desc_req(rand64());
      pick = $urandom_range(0, 99);
      if (lv < 3) begin
        if (pick < 70) begin
          req.descriptor[1:0] = aptw_pkg::DESC_TABLE_PAGE;
          lv++;
        end else if (pick < 86) begin
          req.descriptor[1:0] = aptw_pkg::DESC_BLOCK;
          done = 1'b1;
        end else if (pick < 94) begin
          req.descriptor[1:0] = {1'($urandom), 1'b0};
          done = 1'b1;
        end else begin
          // restart in the middle of a walk
          req = start_req(rand48());
          lv  = top;
        end
      end else begin
        if (pick < 80) req.descriptor[1:0] = aptw_pkg::DESC_TABLE_PAGE;
        else if (pick < 90) req.descriptor[1:0] = aptw_pkg::DESC_BLOCK;
        else req.descriptor[1:0] = {1'($urandom), 1'b0};
        done = 1'b1;
      end
      send_request(req);
    end
  endtask

  initial begin : stimulus
    aptw_pkg::aptw_in_t req;
    int       goal;
    bit       paused;
    snd_idle_pct = 22;
    rcv_idle_pct = 64;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 4k granule, four levels, base 0
    send_request(desc_req('1));
    send_request(start_req('1));
    send_request(desc_req('1));
    send_request(desc_req(64'hFFFF_FFFF_FFFF_FFFD));
    send_request(start_req('0));
    send_request(desc_req(64'h0000_0000_0000_0003));
    send_request(desc_req(64'h0000_0000_0000_1003));
    send_request(desc_req(64'hFFFF_0000_0000_2003));
    send_request(desc_req(64'h0000_8000_0000_0003));
    send_request(start_req(48'h1234_5678_9ABC));
    send_request(start_req(48'h0FED_CBA9_8765));
    send_request(desc_req(64'h0));
    send_request(desc_req(64'h2));
    send_request(start_req(rand48()));
    repeat (3) send_request(desc_req({rand64() | 64'h3}));
    req = desc_req(rand64());
    req.descriptor[1:0] = aptw_pkg::DESC_BLOCK;
    send_request(req);
    drain();

    // reserved granule, level count below range, unaligned base
    configure(2'd3, 3'd0, '1);
    send_request(start_req('1));
    send_request(desc_req('1));
    drain();

    // 64k, level count above range, block wider than the physical space
    configure(aptw_pkg::GRAN_64K, 3'd7, rand48());
    send_request(start_req(rand48()));
    send_request(desc_req(64'hFFFF_FFFF_FFFF_FFFD));
    drain();

    configure(aptw_pkg::GRAN_16K, 3'd5, '0);
    send_request(start_req(rand48()));
    send_request(desc_req(rand64() | 64'h3));
    send_request(desc_req(rand64() | 64'h3));
    send_request(desc_req(64'hFFFF_FFFF_FFFF_FFFE));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 64 : 0;
      rcv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 22 : 0;
      for (int c = 0; c < 4; c++) begin
        if (c == 0 && ph == 0) configure(2'd0, 3'd1, '0);
        else if (c == 0 && ph == 1) configure(aptw_pkg::GRAN_64K, 3'd4, '1);
        else if (c == 0) configure(aptw_pkg::GRAN_16K, 3'd4, rand48());
        else configure(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rand48());
        // long receiver hold-off while requests keep coming
        if (ph == 2 && c == 1) hold_seq++;
        paused = 1'b0;
        goal   = sent + CHUNK;
        while (sent < goal) begin
          if (ph == 2 && c == 2 && !paused && sent >= goal - CHUNK / 2) begin
            drain();
            paused = 1'b1;
          end
          if ($urandom_range(0, 99) < 85) begin
            run_walk();
          end else begin
            req.cmd        = aptw_pkg::aptw_cmd_t'($urandom_range(0, 1));
            req.virt_addr  = rand48();
            req.descriptor = rand64();
            send_request(req);
          end
        end
        drain();
      end
    end

    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

@@ arm64_page_table_walker.f @@
+incdir+hw/rtl
hw/rtl/aptw_pkg.sv
hw/rtl/aptw_cfg.sv
hw/rtl/aptw_walk.sv
hw/rtl/arm64_page_table_walker.sv
verif/testbench.sv
